@@ sv/bfp_pkg.sv @@
// Shared types, codes and constants of the frame parser.
`timescale 1ns / 1ps

package bfp_pkg;

   typedef logic [8:0] offset_type;

   typedef enum logic [1:0] {
      MODE_HUNT,
      MODE_COLLECT,
      MODE_SKIP,
      MODE_IGNORE
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CELL_RD,
      ST_CELL_OUT,
      ST_SUMMARY,
      ST_MARK
   } ctrl_state_type;

   localparam logic [1:0] KIND_CELL     = 2'd0;
   localparam logic [1:0] KIND_SUMMARY  = 2'd1;
   localparam logic [1:0] KIND_SETTINGS = 2'd2;
   localparam logic [1:0] KIND_INFO     = 2'd3;

   localparam logic [7:0] TYPE_SETTINGS = 8'd1;
   localparam logic [7:0] TYPE_CELLS    = 8'd2;
   localparam logic [7:0] TYPE_INFO     = 8'd3;

   localparam offset_type OFF_TYPE      = 9'd4;
   localparam offset_type OFF_CELL_BASE = 9'd6;
   localparam offset_type OFF_CELL_HI   = 9'd7;
   localparam offset_type OFF_PACK_HI   = 9'd119;
   localparam offset_type OFF_CUR_HI    = 9'd127;
   localparam offset_type OFF_TEMP1_HI  = 9'd131;
   localparam offset_type OFF_TEMP2_HI  = 9'd133;
   localparam offset_type SKIP_COUNT    = 9'd3;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [4:0]         cell_index;
      logic [15:0]        cell_millivolts;
      logic [4:0]         cell_count;
      logic [15:0]        pack_millivolts;
      logic signed [15:0] current_milliamps;
      logic [15:0]        temp_first;
      logic [15:0]        temp_second;
      logic [7:0]         frame_type;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic cell_rd;
      logic load_cell;
      logic load_summary;
      logic load_mark;
   } cmd_type;

   typedef struct packed {
      logic frame_cells;
      logic frame_mark;
      logic no_cells;
      logic last_cell;
      logic out_free;
   } status_type;

   function automatic logic [7:0] header_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0: b = 8'h55;
         2'd1: b = 8'hAA;
         2'd2: b = 8'hEB;
         default: b = 8'h90;
      endcase
      return b;
   endfunction

endpackage

@@ sv/bfp_ctrl.sv @@
// Controller: input acceptance and result emission sequencing.
`timescale 1ns / 1ps

module bfp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bfp_pkg::status_type status,
   output bfp_pkg::cmd_type    cmd
);

   bfp_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfp_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.frame_cells) begin
                  state_in = status.no_cells ? bfp_pkg::ST_SUMMARY : bfp_pkg::ST_CELL_RD;
               end else if (status.frame_mark) begin
                  state_in = bfp_pkg::ST_MARK;
               end
            end
         end
         bfp_pkg::ST_CELL_RD: state_in = bfp_pkg::ST_CELL_OUT;
         bfp_pkg::ST_CELL_OUT: begin
            if (status.out_free) begin
               state_in = status.last_cell ? bfp_pkg::ST_SUMMARY : bfp_pkg::ST_CELL_RD;
            end
         end
         bfp_pkg::ST_SUMMARY: begin
            if (status.out_free) state_in = bfp_pkg::ST_IDLE;
         end
         bfp_pkg::ST_MARK: begin
            if (status.out_free) state_in = bfp_pkg::ST_IDLE;
         end
         default: state_in = bfp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall        = (state_ff != bfp_pkg::ST_IDLE);
      cmd.accept       = req_valid && (state_ff == bfp_pkg::ST_IDLE);
      cmd.cell_rd      = (state_ff == bfp_pkg::ST_CELL_RD);
      cmd.load_cell    = (state_ff == bfp_pkg::ST_CELL_OUT) && status.out_free;
      cmd.load_summary = (state_ff == bfp_pkg::ST_SUMMARY) && status.out_free;
      cmd.load_mark    = (state_ff == bfp_pkg::ST_MARK) && status.out_free;
   end

endmodule

@@ sv/bfp_datapath.sv @@
// Datapath: header hunt, frame field capture, cell memory and result register.
`timescale 1ns / 1ps

module bfp_datapath #(
   parameter int MAX_CELLS  = 24,
   parameter int FRAME_NEED = 300
) (
   input  logic                clock,
   input  logic                reset,
   input  bfp_pkg::req_type    req_data,
   input  bfp_pkg::cmd_type    cmd,
   output bfp_pkg::status_type status,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output bfp_pkg::rsp_type    rsp_data
);

   localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CW = $clog2(MAX_CELLS + 1);
   localparam bfp_pkg::offset_type CELL_END = bfp_pkg::offset_type'(6 + 2 * MAX_CELLS);
   localparam bfp_pkg::offset_type NEED     = bfp_pkg::offset_type'(FRAME_NEED);

   logic [1:0]          matched_ff, matched_in;
   bfp_pkg::mode_type   mode_ff, mode_in;
   bfp_pkg::offset_type offset_ff, offset_in;
   logic [7:0]          type_ff, type_in;
   logic [7:0]          low_ff, low_in;
   logic [CW-1:0]       found_ff, found_in;
   logic                counting_ff, counting_in;
   logic [15:0]         pack_ff, pack_in;
   logic [15:0]         cur_ff, cur_in;
   logic [15:0]         temp1_ff, temp1_in;
   logic [15:0]         temp2_ff, temp2_in;
   logic [CW-1:0]       emit_idx_ff, emit_idx_in;
   logic [15:0]         rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   bfp_pkg::rsp_type    rsp_ff, rsp_in;

   logic [15:0]         cell_mem [MAX_CELLS];
   logic                cell_we;
   logic [IW-1:0]       cell_wr_idx;

   logic [7:0]          b;
   logic [15:0]         word;
   bfp_pkg::offset_type off_rel;
   bfp_pkg::offset_type off_dec;
   logic                at_end;

   assign b       = req_data.rx_byte;
   assign word    = {b, low_ff};
   assign off_rel = offset_ff - bfp_pkg::OFF_CELL_BASE;
   assign off_dec = (offset_ff != '0) ? offset_ff - bfp_pkg::offset_type'(1) : offset_ff;
   assign at_end  = (mode_ff == bfp_pkg::MODE_COLLECT) && (offset_ff >= NEED);
   assign cell_wr_idx = off_rel[IW:1];

   always_comb begin
      matched_in  = matched_ff;
      mode_in     = mode_ff;
      offset_in   = offset_ff;
      type_in     = type_ff;
      low_in      = low_ff;
      found_in    = found_ff;
      counting_in = counting_ff;
      pack_in     = pack_ff;
      cur_in      = cur_ff;
      temp1_in    = temp1_ff;
      temp2_in    = temp2_ff;
      cell_we     = 1'b0;
      if (cmd.accept) begin
         unique case (mode_ff)
            bfp_pkg::MODE_HUNT: begin
               if (b == bfp_pkg::header_byte(matched_ff)) begin
                  if (matched_ff == 2'd3) begin
                     matched_in  = 2'd0;
                     mode_in     = bfp_pkg::MODE_COLLECT;
                     offset_in   = bfp_pkg::OFF_TYPE;
                     found_in    = '0;
                     counting_in = 1'b1;
                  end else begin
                     matched_in = matched_ff + 2'd1;
                  end
               end else begin
                  matched_in = (b == bfp_pkg::header_byte(2'd0)) ? 2'd1 : 2'd0;
               end
            end
            bfp_pkg::MODE_COLLECT: begin
               if (offset_ff == bfp_pkg::OFF_TYPE) type_in = b;
               if (offset_ff >= bfp_pkg::OFF_CELL_HI && offset_ff[0] &&
                   offset_ff < CELL_END && counting_ff) begin
                  if (word == 16'd0) begin
                     counting_in = 1'b0;
                  end else begin
                     cell_we  = 1'b1;
                     found_in = found_ff + CW'(1);
                  end
               end
               if (offset_ff == bfp_pkg::OFF_PACK_HI)  pack_in  = word;
               if (offset_ff == bfp_pkg::OFF_CUR_HI)   cur_in   = word;
               if (offset_ff == bfp_pkg::OFF_TEMP1_HI) temp1_in = word;
               if (offset_ff == bfp_pkg::OFF_TEMP2_HI) temp2_in = word;
               low_in = b;
               if (at_end) begin
                  if (type_ff == bfp_pkg::TYPE_CELLS) begin
                     mode_in = bfp_pkg::MODE_IGNORE;
                  end else begin
                     mode_in   = bfp_pkg::MODE_SKIP;
                     offset_in = bfp_pkg::SKIP_COUNT;
                  end
               end else begin
                  offset_in = offset_ff + bfp_pkg::offset_type'(1);
               end
            end
            bfp_pkg::MODE_SKIP: begin
               offset_in = off_dec;
               if (off_dec == '0) begin
                  mode_in    = bfp_pkg::MODE_HUNT;
                  matched_in = 2'd0;
               end
            end
            default: ;
         endcase
         if (req_data.buffer_end) begin
            matched_in = 2'd0;
            mode_in    = bfp_pkg::MODE_HUNT;
            offset_in  = '0;
         end
      end
   end

   always_comb begin
      emit_idx_in = emit_idx_ff;
      if (cmd.accept) begin
         emit_idx_in = '0;
      end else if (cmd.load_cell) begin
         emit_idx_in = emit_idx_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_cell || cmd.load_summary || cmd.load_mark) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.frame_type = type_ff;
         if (cmd.load_cell) begin
            rsp_in.kind            = bfp_pkg::KIND_CELL;
            rsp_in.cell_index      = 5'(emit_idx_ff);
            rsp_in.cell_millivolts = rd_data_ff;
         end else if (cmd.load_summary) begin
            rsp_in.kind              = bfp_pkg::KIND_SUMMARY;
            rsp_in.cell_count        = 5'(found_ff);
            rsp_in.pack_millivolts   = pack_ff;
            rsp_in.current_milliamps = cur_ff;
            rsp_in.temp_first        = temp1_ff;
            rsp_in.temp_second       = temp2_ff;
            rsp_in.last              = 1'b1;
         end else begin
            rsp_in.kind = (type_ff == bfp_pkg::TYPE_SETTINGS) ?
                          bfp_pkg::KIND_SETTINGS : bfp_pkg::KIND_INFO;
            rsp_in.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff   <= 2'd0;
         mode_ff      <= bfp_pkg::MODE_HUNT;
         offset_ff    <= '0;
         type_ff      <= '0;
         low_ff       <= '0;
         found_ff     <= '0;
         counting_ff  <= 1'b1;
         pack_ff      <= '0;
         cur_ff       <= '0;
         temp1_ff     <= '0;
         temp2_ff     <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         matched_ff   <= matched_in;
         mode_ff      <= mode_in;
         offset_ff    <= offset_in;
         type_ff      <= type_in;
         low_ff       <= low_in;
         found_ff     <= found_in;
         counting_ff  <= counting_in;
         pack_ff      <= pack_in;
         cur_ff       <= cur_in;
         temp1_ff     <= temp1_in;
         temp2_ff     <= temp2_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_wr_idx] <= word;
   end

   always_ff @(posedge clock) begin
      if (cmd.cell_rd) rd_data_ff <= cell_mem[emit_idx_ff[IW-1:0]];
   end

   assign status.frame_cells = at_end && (type_ff == bfp_pkg::TYPE_CELLS);
   assign status.frame_mark  = at_end && ((type_ff == bfp_pkg::TYPE_SETTINGS) ||
                                          (type_ff == bfp_pkg::TYPE_INFO));
   assign status.no_cells    = (found_ff == '0);
   assign status.last_cell   = (CW'(emit_idx_ff + CW'(1)) == found_ff);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/bms_frame_parser.sv @@
// Top level: received-byte frame parser for battery monitor replies.
// One byte is taken per cycle while parsing and not stalled; results leave through an output register.
// A cell frame's last byte stalls the input while each stored cell word is read from the
// cell memory and emitted in turn (memory read, then output register), then the summary word.
// A settings or info frame's last byte stalls the input while its marker word is loaded.
// Synchronous reset returns the parser to header hunting; the cell memory is not cleared.
`timescale 1ns / 1ps

module bms_frame_parser #(
   parameter int MAX_CELLS  = 24,
   parameter int FRAME_NEED = 300
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bfp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bfp_pkg::rsp_type rsp_data
);

   bfp_pkg::cmd_type    cmd;
   bfp_pkg::status_type status;

   bfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bfp_datapath #(
      .MAX_CELLS  (MAX_CELLS),
      .FRAME_NEED (FRAME_NEED)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/bfp_checker.sv @@
// Port-level checker for the frame parser, with its bind.
`timescale 1ns / 1ps

module bfp_checker #(
   parameter int MAX_CELLS = 24
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input bfp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bfp_pkg::rsp_type rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("input word changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_cell_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == bfp_pkg::KIND_CELL) |-> !rsp_data.last)
      else $error("cell word marked last");

   a_other_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != bfp_pkg::KIND_CELL) |-> rsp_data.last)
      else $error("summary or marker word not marked last");

   a_cell_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == bfp_pkg::KIND_CELL) |->
         (rsp_data.cell_millivolts != 16'd0) && (32'(rsp_data.cell_index) < MAX_CELLS))
      else $error("bad cell word");

endmodule

bind bms_frame_parser bfp_checker #(.MAX_CELLS(MAX_CELLS)) u_bfp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
